@@ hdl/ber_tlv_list_parse_and_locate_macros.svh @@
// Assertion macros used by the parser core.
`ifndef BER_TLV_LIST_PARSE_AND_LOCATE_MACROS_SVH
`define BER_TLV_LIST_PARSE_AND_LOCATE_MACROS_SVH

// Check cons in the same cycle as ante.
`define BTLP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("btlp: same-cycle check failed");

// Check cons in the cycle after ante.
`define BTLP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("btlp: next-cycle check failed");

`endif

@@ hdl/btlp_pkg.sv @@
package btlp_pkg;

    localparam int MAX_LIST_BYTES_DEF = 2048;

    localparam int BYTE_W        = 8;
    localparam int TAG_W         = 32;
    localparam int TAG_LEN_W     = 3;
    localparam int LEN_ACC_W     = 24;
    localparam int ROLE_W        = 2;
    localparam int ERR_W         = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int TAG_MAX_BYTES = 4;

    localparam logic [BYTE_W-1:0] TAG_ESC   = 8'h1F;
    localparam logic [BYTE_W-1:0] BYTE_MORE = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_LONG1 = 8'h81;
    localparam logic [BYTE_W-1:0] LEN_LONG2 = 8'h82;
    localparam logic [BYTE_W-1:0] LEN_LONG3 = 8'h83;

    localparam logic [ROLE_W-1:0] ROLE_TAG = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_LEN = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_VAL = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_IGN = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO_TAG  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TAG_LONG  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LEN_FORM  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_VAL_LONG  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd5;
    localparam logic [ERR_W-1:0] ERR_LIST_LONG = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TAG     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TAG_LEN = 1'b1;

    typedef enum logic [3:0] {
        PH_TAG = 4'b0001,
        PH_LEN = 4'b0010,
        PH_VAL = 4'b0100,
        PH_ERR = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [TAG_LEN_W-1:0] tag_len;
    } cfg_t;

    function automatic logic [TAG_W-1:0] tag_mask(input logic [TAG_LEN_W-1:0] n);
        logic [TAG_W-1:0] m;
        case (n)
            3'd1:    m = 32'hFF00_0000;
            3'd2:    m = 32'hFFFF_0000;
            3'd3:    m = 32'hFFFF_FF00;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [ERR_W-1:0] first_err(input logic [ERR_W-1:0] cur,
                                                   input logic [ERR_W-1:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

@@ hdl/btlp_if.sv @@
interface btlp_in_if;
    logic                        valid;
    logic                        ready;
    logic [btlp_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface btlp_out_if #(
    parameter int OFF_W  = 11,
    parameter int SIZE_W = 12
);
    logic                        valid;
    logic                        ready;
    logic [btlp_pkg::ROLE_W-1:0] byte_role;
    logic                        element_end;
    logic                        target_value_byte;
    logic                        found;
    logic [OFF_W-1:0]            found_offset;
    logic [SIZE_W-1:0]           found_length;
    logic                        list_end;
    logic                        list_ok;
    logic [btlp_pkg::ERR_W-1:0]  error_code;

    modport source (
        output valid, output byte_role, output element_end, output target_value_byte,
        output found, output found_offset, output found_length, output list_end,
        output list_ok, output error_code, input ready
    );
    modport sink (
        input valid, input byte_role, input element_end, input target_value_byte,
        input found, input found_offset, input found_length, input list_end,
        input list_ok, input error_code, output ready
    );
endinterface

interface btlp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [btlp_pkg::CFG_IDX_W-1:0]  index;
    logic [btlp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/ber_tlv_list_parse_and_locate.sv @@
// BER-TLV list parser and tag locator.
// bytes:   one list byte per word, last_byte set on the final byte of a list.
// results: one word per input byte, in order: the byte's role, element end,
//          target value flag, found offset/length of the first element whose
//          tag equals the configured tag, list end, list status, sticky error.
// cfg:     register writes, index 0 target_tag, index 1 target_tag_len; always
//          ready, write only while no list byte is in flight.
// A result word is registered behind its byte: an accepted byte is held in the
// input register, then passes through the parse logic into the result
// register once that register is free.
// Throughput is one byte per cycle while results does not stall; the parse state
// updates once per byte, so bytes stream back to back.
// When results stalls, the result register holds, the input register takes a byte
// only if it is empty, and bytes.ready stays low while it is full until results moves.
// Reset clears all list state, target_tag to 0 and target_tag_len to 1; the
// state of a list also clears after its final byte, registers keep their values.
module ber_tlv_list_parse_and_locate #(
    parameter int MAX_LIST_BYTES = btlp_pkg::MAX_LIST_BYTES_DEF,
    parameter int OFF_W          = $clog2(MAX_LIST_BYTES),
    parameter int POS_W          = $clog2(MAX_LIST_BYTES + 1)
) (
    input  logic       clk,
    input  logic       rst_n,
    btlp_in_if.sink    bytes,
    btlp_out_if.source results,
    btlp_cfg_if.sink   cfg
);

    logic [btlp_pkg::TAG_W-1:0]     tag_reg;
    logic [btlp_pkg::TAG_LEN_W-1:0] tag_len_reg;
    btlp_pkg::cfg_t                 cfg_val;
    btlp_pkg::stage_t               stage;
    logic                           advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg     <= '0;
            tag_len_reg <= btlp_pkg::TAG_LEN_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                btlp_pkg::REG_TARGET_TAG:     tag_reg     <= cfg.data;
                btlp_pkg::REG_TARGET_TAG_LEN: tag_len_reg <= cfg.data[btlp_pkg::TAG_LEN_W-1:0];
                default:                      tag_reg     <= tag_reg;
            endcase
        end
    end

    assign cfg_val.tag     = tag_reg;
    assign cfg_val.tag_len = tag_len_reg;

    btlp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .stage   (stage)
    );

    btlp_core #(
        .MAX_LIST_BYTES (MAX_LIST_BYTES),
        .OFF_W          (OFF_W),
        .POS_W          (POS_W)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .cfg     (cfg_val),
        .advance (advance),
        .results (results)
    );

endmodule

@@ hdl/btlp_in_stage.sv @@
module btlp_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    btlp_in_if.sink          bytes,
    input  logic             advance,
    output btlp_pkg::stage_t stage
);

    logic            valid_reg;
    logic            valid_next;
    btlp_pkg::item_t item_reg;

    assign bytes.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (bytes.ready)
        begin
            valid_next = bytes.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            item_reg.data_byte <= bytes.data_byte;
            item_reg.last_byte <= bytes.last_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ hdl/btlp_core.sv @@
`include "ber_tlv_list_parse_and_locate_macros.svh"

module btlp_core #(
    parameter int MAX_LIST_BYTES = btlp_pkg::MAX_LIST_BYTES_DEF,
    parameter int OFF_W          = $clog2(MAX_LIST_BYTES),
    parameter int POS_W          = $clog2(MAX_LIST_BYTES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  btlp_pkg::stage_t stage,
    input  btlp_pkg::cfg_t   cfg,
    output logic             advance,
    btlp_out_if.source       results
);

    localparam int CMP_W = (POS_W > btlp_pkg::LEN_ACC_W) ? POS_W : btlp_pkg::LEN_ACC_W;

    typedef struct packed {
        logic [btlp_pkg::ROLE_W-1:0] byte_role;
        logic                        element_end;
        logic                        target_value_byte;
        logic                        found;
        logic [OFF_W-1:0]            found_offset;
        logic [POS_W-1:0]            found_length;
        logic                        list_end;
        logic                        list_ok;
        logic [btlp_pkg::ERR_W-1:0]  error_code;
    } result_t;

    btlp_pkg::phase_t                 phase_reg, phase_next;
    logic [btlp_pkg::TAG_LEN_W-1:0]   tag_seen_reg, tag_seen_next;
    logic [btlp_pkg::TAG_W-1:0]       tag_shift_reg, tag_shift_next;
    logic [1:0]                       len_left_reg, len_left_next;
    logic [btlp_pkg::LEN_ACC_W-1:0]   len_acc_reg, len_acc_next;
    logic [POS_W-1:0]                 val_left_reg, val_left_next;
    logic [POS_W-1:0]                 pos_reg, pos_next;
    logic [OFF_W-1:0]                 elem_start_reg, elem_start_next;
    logic                             is_tgt_reg, is_tgt_next;
    logic                             found_reg, found_next;
    logic [OFF_W-1:0]                 found_start_reg, found_start_next;
    logic [POS_W-1:0]                 found_size_reg, found_size_next;
    logic [btlp_pkg::ERR_W-1:0]       err_reg, err_next;

    logic                             res_valid_reg, res_valid_next;
    result_t                          res_reg, res_next;

    logic [btlp_pkg::BYTE_W-1:0]      b;
    logic                             last;
    logic [btlp_pkg::TAG_LEN_W-1:0]   k;
    logic                             do_ftag;
    logic                             do_bval;
    logic                             do_fel;
    logic [CMP_W-1:0]                 bval_len;
    logic [CMP_W-1:0]                 limit;
    logic [POS_W-1:0]                 val_dec;

    assign advance = stage.valid && (!res_valid_reg || results.ready);
    assign b       = stage.item.data_byte;
    assign last    = stage.item.last_byte;
    assign k       = tag_seen_reg + btlp_pkg::TAG_LEN_W'(1);
    assign limit   = CMP_W'(MAX_LIST_BYTES) - CMP_W'(pos_reg) - CMP_W'(1);
    assign val_dec = (val_left_reg != '0) ? (val_left_reg - POS_W'(1)) : val_left_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        tag_seen_next    = tag_seen_reg;
        tag_shift_next   = tag_shift_reg;
        len_left_next    = len_left_reg;
        len_acc_next     = len_acc_reg;
        val_left_next    = val_left_reg;
        pos_next         = pos_reg;
        elem_start_next  = elem_start_reg;
        is_tgt_next      = is_tgt_reg;
        found_next       = found_reg;
        found_start_next = found_start_reg;
        found_size_next  = found_size_reg;
        err_next         = err_reg;
        res_next         = '0;
        res_next.byte_role = btlp_pkg::ROLE_IGN;
        do_ftag          = 1'b0;
        do_bval          = 1'b0;
        do_fel           = 1'b0;
        bval_len         = '0;

        if (phase_reg == btlp_pkg::PH_ERR)
        begin
            res_next.byte_role = btlp_pkg::ROLE_IGN;
        end
        else if (pos_reg >= POS_W'(MAX_LIST_BYTES))
        begin
            res_next.byte_role = btlp_pkg::ROLE_IGN;
            err_next   = btlp_pkg::first_err(err_next, btlp_pkg::ERR_LIST_LONG);
            phase_next = btlp_pkg::PH_ERR;
        end
        else
        begin
            case (phase_reg)
                btlp_pkg::PH_TAG:
                begin
                    res_next.byte_role = btlp_pkg::ROLE_TAG;
                    if (tag_seen_reg == '0)
                    begin
                        if (b == '0)
                        begin
                            err_next   = btlp_pkg::first_err(err_next, btlp_pkg::ERR_ZERO_TAG);
                            phase_next = btlp_pkg::PH_ERR;
                        end
                        else
                        begin
                            elem_start_next = OFF_W'(pos_reg);
                            tag_shift_next  = {b, 24'h0};
                            tag_seen_next   = btlp_pkg::TAG_LEN_W'(1);
                            do_ftag         = ((b & btlp_pkg::TAG_ESC) != btlp_pkg::TAG_ESC);
                        end
                    end
                    else if ((k >= btlp_pkg::TAG_LEN_W'(btlp_pkg::TAG_MAX_BYTES))
                             && ((b & btlp_pkg::BYTE_MORE) != '0))
                    begin
                        err_next   = btlp_pkg::first_err(err_next, btlp_pkg::ERR_TAG_LONG);
                        phase_next = btlp_pkg::PH_ERR;
                    end
                    else
                    begin
                        case (k)
                            3'd2:    tag_shift_next = tag_shift_reg | {8'h0, b, 16'h0};
                            3'd3:    tag_shift_next = tag_shift_reg | {16'h0, b, 8'h0};
                            default: tag_shift_next = tag_shift_reg | {24'h0, b};
                        endcase
                        tag_seen_next = k;
                        do_ftag = ((b & btlp_pkg::BYTE_MORE) == '0)
                                  || (k >= btlp_pkg::TAG_LEN_W'(btlp_pkg::TAG_MAX_BYTES));
                    end
                end
                btlp_pkg::PH_LEN:
                begin
                    res_next.byte_role = btlp_pkg::ROLE_LEN;
                    if (len_left_reg == '0)
                    begin
                        if (b < btlp_pkg::BYTE_MORE)
                        begin
                            do_bval  = 1'b1;
                            bval_len = CMP_W'(b);
                        end
                        else if (b == btlp_pkg::LEN_LONG1 || b == btlp_pkg::LEN_LONG2
                                 || b == btlp_pkg::LEN_LONG3)
                        begin
                            len_left_next = b[1:0];
                            len_acc_next  = '0;
                        end
                        else
                        begin
                            err_next   = btlp_pkg::first_err(err_next, btlp_pkg::ERR_LEN_FORM);
                            phase_next = btlp_pkg::PH_ERR;
                        end
                    end
                    else
                    begin
                        len_acc_next  = {len_acc_reg[15:0], b};
                        len_left_next = len_left_reg - 2'd1;
                        if (len_left_reg == 2'd1)
                        begin
                            do_bval  = 1'b1;
                            bval_len = CMP_W'(len_acc_next);
                        end
                    end
                end
                btlp_pkg::PH_VAL:
                begin
                    res_next.byte_role         = btlp_pkg::ROLE_VAL;
                    res_next.target_value_byte = is_tgt_reg;
                    val_left_next              = val_dec;
                    do_fel                     = (val_dec == '0);
                end
                default:
                begin
                    res_next.byte_role = btlp_pkg::ROLE_IGN;
                end
            endcase
        end

        if (do_ftag)
        begin
            if (cfg.tag_len >= 3'd1 && cfg.tag_len <= 3'd4 && !found_reg
                && tag_seen_next == cfg.tag_len)
            begin
                is_tgt_next = (tag_shift_next == (cfg.tag & btlp_pkg::tag_mask(cfg.tag_len)));
            end
            else
            begin
                is_tgt_next = 1'b0;
            end
            len_left_next = '0;
            phase_next    = btlp_pkg::PH_LEN;
        end

        if (do_bval)
        begin
            if (bval_len > limit)
            begin
                err_next   = btlp_pkg::first_err(err_next, btlp_pkg::ERR_VAL_LONG);
                phase_next = btlp_pkg::PH_ERR;
            end
            else if (bval_len == '0)
            begin
                do_fel = 1'b1;
            end
            else
            begin
                val_left_next = POS_W'(bval_len);
                phase_next    = btlp_pkg::PH_VAL;
            end
        end

        if (do_fel)
        begin
            res_next.element_end = 1'b1;
            if (is_tgt_reg)
            begin
                found_next       = 1'b1;
                found_start_next = elem_start_reg;
                found_size_next  = pos_reg + POS_W'(1) - POS_W'(elem_start_reg);
            end
            is_tgt_next   = 1'b0;
            tag_seen_next = '0;
            phase_next    = btlp_pkg::PH_TAG;
        end

        if (pos_reg < POS_W'(MAX_LIST_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        if (last)
        begin
            if (err_next == btlp_pkg::ERR_NONE
                && (phase_next != btlp_pkg::PH_TAG || tag_seen_next != '0))
            begin
                err_next   = btlp_pkg::ERR_TRUNCATED;
                phase_next = btlp_pkg::PH_ERR;
            end
            res_next.list_ok = (err_next == btlp_pkg::ERR_NONE);
        end

        res_next.list_end     = last;
        res_next.found        = found_next;
        res_next.found_offset = found_next ? found_start_next : '0;
        res_next.found_length = found_next ? found_size_next : '0;
        res_next.error_code   = err_next;

        // Drop all list state after the final byte.
        if (last)
        begin
            phase_next       = btlp_pkg::PH_TAG;
            tag_seen_next    = '0;
            tag_shift_next   = '0;
            len_left_next    = '0;
            len_acc_next     = '0;
            val_left_next    = '0;
            pos_next         = '0;
            elem_start_next  = '0;
            is_tgt_next      = 1'b0;
            found_next       = 1'b0;
            found_start_next = '0;
            found_size_next  = '0;
            err_next         = btlp_pkg::ERR_NONE;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= btlp_pkg::PH_TAG;
            tag_seen_reg    <= '0;
            tag_shift_reg   <= '0;
            len_left_reg    <= '0;
            len_acc_reg     <= '0;
            val_left_reg    <= '0;
            pos_reg         <= '0;
            elem_start_reg  <= '0;
            is_tgt_reg      <= 1'b0;
            found_reg       <= 1'b0;
            found_start_reg <= '0;
            found_size_reg  <= '0;
            err_reg         <= btlp_pkg::ERR_NONE;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg       <= phase_next;
                tag_seen_reg    <= tag_seen_next;
                tag_shift_reg   <= tag_shift_next;
                len_left_reg    <= len_left_next;
                len_acc_reg     <= len_acc_next;
                val_left_reg    <= val_left_next;
                pos_reg         <= pos_next;
                elem_start_reg  <= elem_start_next;
                is_tgt_reg      <= is_tgt_next;
                found_reg       <= found_next;
                found_start_reg <= found_start_next;
                found_size_reg  <= found_size_next;
                err_reg         <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid             = res_valid_reg;
    assign results.byte_role         = res_reg.byte_role;
    assign results.element_end       = res_reg.element_end;
    assign results.target_value_byte = res_reg.target_value_byte;
    assign results.found             = res_reg.found;
    assign results.found_offset      = res_reg.found_offset;
    assign results.found_length      = res_reg.found_length;
    assign results.list_end          = res_reg.list_end;
    assign results.list_ok           = res_reg.list_ok;
    assign results.error_code        = res_reg.error_code;

    `BTLP_ASSERT_IMP(a_ign_has_err, clk, rst_n,
        res_valid_reg && res_reg.byte_role == btlp_pkg::ROLE_IGN,
        res_reg.error_code != btlp_pkg::ERR_NONE)
    `BTLP_ASSERT_IMP(a_ok_matches_err, clk, rst_n,
        res_valid_reg && res_reg.list_end,
        res_reg.list_ok == (res_reg.error_code == btlp_pkg::ERR_NONE))
    `BTLP_ASSERT_IMP(a_not_found_zero, clk, rst_n,
        res_valid_reg && !res_reg.found,
        res_reg.found_offset == '0 && res_reg.found_length == '0)
    `BTLP_ASSERT_IMP(a_end_role, clk, rst_n,
        res_valid_reg && res_reg.element_end,
        res_reg.byte_role == btlp_pkg::ROLE_LEN || res_reg.byte_role == btlp_pkg::ROLE_VAL)
    `BTLP_ASSERT_NXT(a_list_clear, clk, rst_n,
        advance && last,
        pos_reg == '0 && phase_reg == btlp_pkg::PH_TAG && err_reg == btlp_pkg::ERR_NONE)

endmodule
